// ----- sv/tpsr_pkg.sv -----
package tpsr_pkg;

  localparam int TILE_SIDE  = 8;
  localparam int TILE_SHIFT = 3;
  localparam int COL_SUM_W  = 14;
  localparam int ROW_SUM_W  = 13;

  typedef enum logic [1:0] {
    MODE_MAP_WR  = 2'd0,
    MODE_TILE_WR = 2'd1,
    MODE_RENDER  = 2'd2
  } tpsr_mode_e;

  typedef enum logic [2:0] {
    CFG_VSCROLL      = 3'd0,
    CFG_FIRST_LINE   = 3'd1,
    CFG_WATER_LINE   = 3'd2,
    CFG_WATER_ALL    = 3'd3,
    CFG_WATER_OFFSET = 3'd4
  } tpsr_cfg_idx_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  map_col;
    logic [4:0]  map_row;
    logic [12:0] map_entry;
    logic [10:0] tile_number;
    logic [2:0]  pixel_row;
    logic [2:0]  pixel_col;
    logic [7:0]  pixel_value;
    logic [9:0]  disp_x;
    logic [9:0]  disp_y;
    logic [15:0] line_scroll;
    logic [7:0]  under_pixel;
  } req_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       opaque;
  } res_t;

  typedef struct packed {
    logic [15:0]        vertical_scroll;
    logic [9:0]         first_line;
    logic signed [15:0] water_line;
    logic               water_all;
    logic [7:0]         water_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    vertical_scroll: 16'd0,
    first_line:      10'd0,
    water_line:      -16'sd1,
    water_all:       1'b0,
    water_offset:    8'd0
  };

  typedef struct packed {
    logic       valid;
    req_t       req;
    logic       render_ok;
    logic       water;
    logic       tile_ok;
    logic [2:0] tcol;
    logic [2:0] trow;
  } pipe_t;

endpackage

// ----- sv/tpsr_ram.sv -----
module tpsr_ram import tpsr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tpsr_geom.sv -----
module tpsr_geom import tpsr_pkg::*; #(
  parameter int MAP_COLS     = 64,
  parameter int MAP_ROWS     = 32,
  parameter int SCREEN_TILES = 50,
  parameter int CENTER_SHIFT = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  req_t                        req_i,
  input  cfg_t                        cfg_i,
  output pipe_t                       pipe_o,
  output logic [$clog2(MAP_COLS)-1:0] map_col_o,
  output logic [$clog2(MAP_ROWS)-1:0] map_row_o
);

  localparam int CW = $clog2(MAP_COLS);
  localparam int RW = $clog2(MAP_ROWS);
  localparam int NC = COL_SUM_W;
  localparam int NR = ROW_SUM_W;
  localparam int MC = (1 << NC) / MAP_COLS;
  localparam int MR = (1 << NR) / MAP_ROWS;

  logic [15:0]   h, v;
  logic [10:0]   hx;
  logic [NC-1:0] colsum;
  pipe_t         a_d;

  pipe_t         a_pipe_q, b_pipe_q, c_pipe_q, d_pipe_q;
  logic [NC-1:0] a_colsum_q, b_colsum_q, c_rc_q;
  logic [NR-1:0] a_rowsum_q, b_rowsum_q, c_rr_q;
  logic [NC-1:0] b_qc_q;
  logic [NR-1:0] b_qr_q;
  logic [CW-1:0] d_col_q;
  logic [RW-1:0] d_row_q;

  logic [2*NC-1:0] prod_qc, prod_rc;
  logic [2*NR-1:0] prod_qr, prod_rr;
  logic [NC-1:0]   rc_fix;
  logic [NR-1:0]   rr_fix;

  always_comb begin
    h      = req_i.line_scroll - 16'(CENTER_SHIFT);
    hx     = 11'(h[2:0]) + 11'(req_i.disp_x);
    colsum = NC'(h[15:3]) + NC'(hx[10:3]);
    v      = cfg_i.vertical_scroll + 16'(req_i.disp_y) - 16'(cfg_i.first_line);

    a_d           = '0;
    a_d.valid     = in_valid_i;
    a_d.req       = req_i;
    a_d.render_ok = (req_i.disp_y >= cfg_i.first_line) &&
                    ({1'b0, req_i.disp_x} < 11'(SCREEN_TILES * TILE_SIDE));
    a_d.water     = cfg_i.water_all ||
                    ($signed({6'b0, req_i.disp_y}) > cfg_i.water_line);
    a_d.tcol      = hx[2:0];
    a_d.trow      = v[2:0];
  end

  // reciprocal estimate of the quotient, low by at most one
  assign prod_qc = (2*NC)'(a_colsum_q) * (2*NC)'(MC);
  assign prod_qr = (2*NR)'(a_rowsum_q) * (2*NR)'(MR);
  assign prod_rc = (2*NC)'(b_qc_q) * (2*NC)'(MAP_COLS);
  assign prod_rr = (2*NR)'(b_qr_q) * (2*NR)'(MAP_ROWS);

  assign rc_fix = (c_rc_q >= NC'(MAP_COLS)) ? c_rc_q - NC'(MAP_COLS) : c_rc_q;
  assign rr_fix = (c_rr_q >= NR'(MAP_ROWS)) ? c_rr_q - NR'(MAP_ROWS) : c_rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pipe_q <= '0;
      b_pipe_q <= '0;
      c_pipe_q <= '0;
      d_pipe_q <= '0;
    end else begin
      a_pipe_q <= a_d;
      b_pipe_q <= a_pipe_q;
      c_pipe_q <= b_pipe_q;
      d_pipe_q <= c_pipe_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_colsum_q <= colsum;
    a_rowsum_q <= v[15:3];
    b_colsum_q <= a_colsum_q;
    b_rowsum_q <= a_rowsum_q;
    b_qc_q     <= prod_qc[2*NC-1:NC];
    b_qr_q     <= prod_qr[2*NR-1:NR];
    c_rc_q     <= b_colsum_q - prod_rc[NC-1:0];
    c_rr_q     <= b_rowsum_q - prod_rr[NR-1:0];
    if (c_pipe_q.req.mode == MODE_MAP_WR) begin
      d_col_q <= CW'(c_pipe_q.req.map_col);
      d_row_q <= RW'(c_pipe_q.req.map_row);
    end else begin
      d_col_q <= CW'(rc_fix);
      d_row_q <= RW'(rr_fix);
    end
  end

  assign pipe_o    = d_pipe_q;
  assign map_col_o = d_col_q;
  assign map_row_o = d_row_q;

endmodule

// ----- sv/tpsr_fetch.sv -----
module tpsr_fetch import tpsr_pkg::*; #(
  parameter int MAP_COLS   = 64,
  parameter int MAP_ROWS   = 32,
  parameter int TILE_COUNT = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pipe_t                       pipe_i,
  input  logic [$clog2(MAP_COLS)-1:0] map_col_i,
  input  logic [$clog2(MAP_ROWS)-1:0] map_row_i,
  output pipe_t                       pipe_o,
  output logic [7:0]                  pixel_o,
  output logic                        clearing_o
);

  localparam int MAP_DEPTH  = MAP_COLS * MAP_ROWS;
  localparam int MAW        = $clog2(MAP_DEPTH);
  localparam int TNW        = $clog2(TILE_COUNT);
  localparam int TILE_DEPTH = TILE_COUNT * TILE_SIDE * TILE_SIDE;
  localparam int TAW        = $clog2(TILE_DEPTH);

  pipe_t          e_pipe_q, f_pipe_q, g_pipe_q;
  logic [MAW-1:0] e_addr_q;
  logic           e_wr_q;
  logic           clr_active_q;
  logic [MAW-1:0] clr_addr_q;

  logic           map_we;
  logic [MAW-1:0] map_waddr;
  logic [12:0]    map_wdata, entry;
  logic           wr_ok;

  logic [10:0]    tile;
  logic           tile_ok;
  logic [2:0]     trow_f, tcol_f;
  logic           tile_we;
  logic [TAW-1:0] tile_raddr, tile_waddr;
  pipe_t          g_d;

  assign wr_ok = pipe_i.valid && (pipe_i.req.mode == MODE_MAP_WR) &&
                 (8'(pipe_i.req.map_col) < 8'(MAP_COLS)) &&
                 (8'(pipe_i.req.map_row) < 8'(MAP_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_pipe_q     <= '0;
      f_pipe_q     <= '0;
      g_pipe_q     <= '0;
      e_wr_q       <= 1'b0;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      e_pipe_q <= pipe_i;
      f_pipe_q <= e_pipe_q;
      g_pipe_q <= g_d;
      e_wr_q   <= wr_ok;
      if (clr_active_q) begin
        if (clr_addr_q == MAW'(MAP_DEPTH - 1)) begin
          clr_active_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_addr_q <= MAW'(map_row_i) * MAW'(MAP_COLS) + MAW'(map_col_i);
  end

  assign map_we    = clr_active_q || e_wr_q;
  assign map_waddr = clr_active_q ? clr_addr_q : e_addr_q;
  assign map_wdata = clr_active_q ? 13'd0 : e_pipe_q.req.map_entry;

  tpsr_ram #(
    .WIDTH(13),
    .DEPTH(MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (e_addr_q),
    .rdata_o (entry)
  );

  // flip by mirroring the tile coordinates at fetch
  always_comb begin
    tile    = entry[10:0];
    tile_ok = (tile != 11'd0) && (12'(tile) < 12'(TILE_COUNT));
    tcol_f  = f_pipe_q.tcol ^ {3{entry[11]}};
    trow_f  = f_pipe_q.trow ^ {3{entry[12]}};
    tile_raddr = {TNW'(tile), trow_f, tcol_f};
    tile_waddr = {TNW'(f_pipe_q.req.tile_number), f_pipe_q.req.pixel_row,
                  f_pipe_q.req.pixel_col};
    tile_we = f_pipe_q.valid && (f_pipe_q.req.mode == MODE_TILE_WR) &&
              (12'(f_pipe_q.req.tile_number) < 12'(TILE_COUNT));
    g_d         = f_pipe_q;
    g_d.tile_ok = tile_ok;
  end

  tpsr_ram #(
    .WIDTH(8),
    .DEPTH(TILE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (tile_waddr),
    .wdata_i (f_pipe_q.req.pixel_value),
    .raddr_i (tile_raddr),
    .rdata_o (pixel_o)
  );

  assign pipe_o     = g_pipe_q;
  assign clearing_o = clr_active_q;

endmodule

// ----- sv/tile_plane_scanline_renderer_unit.sv -----
// path: a render transaction accepted while busy_o is low passes the geometry
// registers a to d, the fetch registers e to g and the done register before it
// is strobed on done_o, where the receiver accepts it
// throughput: one transaction per cycle while busy_o is low, set by the 8-stage
// pipeline with one read of the map and one of the tile memory per transaction
// reset: busy_o stays high while the plane map is cleared; here the receiver cannot stall
module tile_plane_scanline_renderer_unit import tpsr_pkg::*; #(
  parameter int MAP_COLS     = 64,
  parameter int MAP_ROWS     = 32,
  parameter int TILE_COUNT   = 2048,
  parameter int SCREEN_TILES = 50,
  parameter int CENTER_SHIFT = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output res_t        result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW = $clog2(MAP_COLS);
  localparam int RW = $clog2(MAP_ROWS);

  cfg_t          cfg_q, cfg_d;
  pipe_t         geom_pipe, fetch_pipe;
  logic [CW-1:0] map_col;
  logic [RW-1:0] map_row;
  logic [7:0]    pixel;
  logic          clearing;
  logic          done_q;
  res_t          result_q, result_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VSCROLL:      cfg_d.vertical_scroll = cfg_data_i;
        CFG_FIRST_LINE:   cfg_d.first_line      = cfg_data_i[9:0];
        CFG_WATER_LINE:   cfg_d.water_line      = $signed(cfg_data_i);
        CFG_WATER_ALL:    cfg_d.water_all       = cfg_data_i[0];
        CFG_WATER_OFFSET: cfg_d.water_offset    = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      done_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      done_q <= fetch_pipe.valid && (fetch_pipe.req.mode == MODE_RENDER);
    end
  end

  tpsr_geom #(
    .MAP_COLS     (MAP_COLS),
    .MAP_ROWS     (MAP_ROWS),
    .SCREEN_TILES (SCREEN_TILES),
    .CENTER_SHIFT (CENTER_SHIFT)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start_i && !busy_o),
    .req_i      (req_i),
    .cfg_i      (cfg_q),
    .pipe_o     (geom_pipe),
    .map_col_o  (map_col),
    .map_row_o  (map_row)
  );

  tpsr_fetch #(
    .MAP_COLS   (MAP_COLS),
    .MAP_ROWS   (MAP_ROWS),
    .TILE_COUNT (TILE_COUNT)
  ) u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pipe_i     (geom_pipe),
    .map_col_i  (map_col),
    .map_row_i  (map_row),
    .pipe_o     (fetch_pipe),
    .pixel_o    (pixel),
    .clearing_o (clearing)
  );

  always_comb begin
    result_d.out_pixel = fetch_pipe.req.under_pixel;
    result_d.opaque    = 1'b0;
    if (fetch_pipe.render_ok && fetch_pipe.tile_ok && (pixel != 8'd0)) begin
      result_d.opaque    = 1'b1;
      result_d.out_pixel = fetch_pipe.water ? pixel + cfg_q.water_offset : pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy_o   = clearing;
  assign done_o   = done_q;
  assign result_o = result_q;

  a_no_done_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy_o |-> !done_o
  ) else $error("result strobe during map clear");

  a_render_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.mode == MODE_RENDER) |-> ##8 done_o
  ) else $error("render transaction without result");

  a_write_gives_none: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.mode != MODE_RENDER) |-> ##8 !done_o
  ) else $error("result strobe for a non-render transaction");

endmodule
